>>> sv/mp3de_pkg.sv
// Shared types, constants and MPEG header lookup functions for the MP3
// duration estimator. No dependencies.
package mp3de_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } in_item_t;

  typedef struct packed {
    logic [29:0] duration_seconds;
    logic [1:0]  duration_source;
  } out_item_t;

  typedef enum logic [1:0] {
    PH_SEARCH,
    PH_COLLECT,
    PH_IDLE
  } phase_e;

  typedef enum logic [1:0] {
    ST_STREAM,
    ST_PREP,
    ST_DIV,
    ST_OUT
  } ctrl_state_e;

  typedef enum logic [1:0] {
    SRC_NONE,
    SRC_XING,
    SRC_VBRI,
    SRC_BITRATE
  } src_e;

  typedef struct packed {
    logic byte_en;
    logic eof_byte;
    logic load;
    logic div_step;
  } dp_cmd_t;

  localparam int unsigned NumW   = 46;
  localparam int unsigned DenW   = 20;
  localparam int unsigned DivCntW = 6;
  localparam int unsigned AfterDepth = 52;

  localparam logic [1:0] VerMpeg1 = 2'd3;
  localparam logic [1:0] VerReserved = 2'd1;
  localparam logic [1:0] LayerIII = 2'd1;
  localparam logic [1:0] ChMono = 2'd3;

  function automatic logic [8:0] kbps_lookup(input logic [1:0] ver, input logic [3:0] bri);
    logic [8:0] k;
    if (ver == VerMpeg1) begin
      case (bri)
        4'd1:  k = 9'd32;
        4'd2:  k = 9'd40;
        4'd3:  k = 9'd48;
        4'd4:  k = 9'd56;
        4'd5:  k = 9'd64;
        4'd6:  k = 9'd80;
        4'd7:  k = 9'd96;
        4'd8:  k = 9'd112;
        4'd9:  k = 9'd128;
        4'd10: k = 9'd160;
        4'd11: k = 9'd192;
        4'd12: k = 9'd224;
        4'd13: k = 9'd256;
        4'd14: k = 9'd320;
        default: k = 9'd0;
      endcase
    end else begin
      case (bri)
        4'd1:  k = 9'd8;
        4'd2:  k = 9'd16;
        4'd3:  k = 9'd24;
        4'd4:  k = 9'd32;
        4'd5:  k = 9'd40;
        4'd6:  k = 9'd48;
        4'd7:  k = 9'd56;
        4'd8:  k = 9'd64;
        4'd9:  k = 9'd80;
        4'd10: k = 9'd96;
        4'd11: k = 9'd112;
        4'd12: k = 9'd128;
        4'd13: k = 9'd144;
        4'd14: k = 9'd160;
        default: k = 9'd0;
      endcase
    end
    return k;
  endfunction

  function automatic logic [15:0] rate_lookup(input logic [1:0] ver, input logic [1:0] sri);
    logic [15:0] r;
    case ({ver, sri})
      4'b00_00: r = 16'd11025;
      4'b00_01: r = 16'd12000;
      4'b00_10: r = 16'd8000;
      4'b10_00: r = 16'd22050;
      4'b10_01: r = 16'd24000;
      4'b10_10: r = 16'd16000;
      4'b11_00: r = 16'd44100;
      4'b11_01: r = 16'd48000;
      4'b11_10: r = 16'd32000;
      default:  r = 16'd0;
    endcase
    return r;
  endfunction

  function automatic logic [5:0] side_lookup(input logic [1:0] ver, input logic [1:0] chm);
    logic [5:0] s;
    if (ver == VerMpeg1) s = (chm == ChMono) ? 6'd17 : 6'd32;
    else                 s = (chm == ChMono) ? 6'd9 : 6'd17;
    return s;
  endfunction

endpackage

>>> sv/mp3de_ctrl.sv
// Controller for the MP3 duration estimator: sequences byte streaming,
// operand load, the bit-serial divide and result hand-off. Uses mp3de_pkg.
module mp3de_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_eof_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output mp3de_pkg::dp_cmd_t  cmd_o
);
  import mp3de_pkg::*;

  ctrl_state_e        state_q, state_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_STREAM;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_STREAM: in_ready_o = 1'b1;
      ST_OUT: begin
        out_valid_o = 1'b1;
        in_ready_o  = out_ready_i;
      end
      default: ;
    endcase
    accept = in_valid_i & in_ready_o;
    cmd_o.byte_en  = accept;
    cmd_o.eof_byte = accept & in_eof_i;
    cmd_o.load     = (state_q == ST_PREP);
    cmd_o.div_step = (state_q == ST_DIV);
    case (state_q)
      ST_STREAM: if (accept && in_eof_i) state_d = ST_PREP;
      ST_PREP: begin
        state_d = ST_DIV;
        cnt_d   = '0;
      end
      ST_DIV: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == DivCntW'(NumW - 1)) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_ready_i) state_d = (accept && in_eof_i) ? ST_PREP : ST_STREAM;
      end
      default: state_d = ST_STREAM;
    endcase
  end

  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PREP) |=> ##(NumW) out_valid_o) else $error("divide length");
  a_no_byte_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.load || cmd_o.div_step) |-> !cmd_o.byte_en) else $error("byte while busy");
  a_eof_prep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.eof_byte |=> (state_q == ST_PREP)) else $error("eof not followed by prep");

endmodule

>>> sv/mp3de_dp.sv
// Datapath for the MP3 duration estimator: tag parsing, frame header search,
// tag field capture, operand setup and a restoring divider. Uses mp3de_pkg.
module mp3de_dp #(
  parameter int unsigned REGION_BYTES = 65536
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mp3de_pkg::dp_cmd_t   cmd_i,
  input  mp3de_pkg::in_item_t  in_data_i,
  output mp3de_pkg::out_item_t out_data_o
);
  import mp3de_pkg::*;

  localparam int unsigned RelW = $clog2(REGION_BYTES);

  logic [31:0]     pos_q, pos_d;
  logic [32:0]     fsize_q;
  logic [7:0]      tag_q [10];
  logic [28:0]     start_q, start_d;
  logic [7:0]      r1_q, r2_q, r3_q, r1_d, r2_d, r3_d;
  phase_e          phase_q, phase_d;
  logic [RelW-1:0] fo_q, fo_d;
  logic [1:0]      ver_q, sri_q, chm_q, ver_d, sri_d, chm_d;
  logic [3:0]      bri_q, bri_d;
  logic [5:0]      k_q, k_d;
  logic            xm_q, im_q, xflag_q, xdone_q, vm_q, vdone_q;
  logic            xm_d, im_d, xflag_d, xdone_d, vm_d, vdone_d;
  logic [31:0]     xcnt_q, vcnt_q, xcnt_d, vcnt_d;
  logic [NumW-1:0] quo_q;
  logic [DenW-1:0] rem_q;
  logic [DenW-1:0] den_q;
  logic [1:0]      src_q;

  logic [31:0] rel32;
  logic        in_reg, hdr_ok, id3;
  logic [RelW-1:0] rel;
  logic [7:0]  b;
  logic [6:0]  kx, side7;

  assign b = in_data_i.data_byte;

  always_comb begin
    pos_d = pos_q; start_d = start_q;
    r1_d = r1_q; r2_d = r2_q; r3_d = r3_q;
    phase_d = phase_q; fo_d = fo_q;
    ver_d = ver_q; bri_d = bri_q; sri_d = sri_q; chm_d = chm_q;
    k_d = k_q; xm_d = xm_q; im_d = im_q; xflag_d = xflag_q; xdone_d = xdone_q;
    vm_d = vm_q; vdone_d = vdone_q; xcnt_d = xcnt_q; vcnt_d = vcnt_q;

    rel32  = pos_q - {3'b0, start_q};
    in_reg = (pos_q >= {3'b0, start_q}) && (rel32 < 32'(REGION_BYTES));
    rel    = rel32[RelW-1:0];
    hdr_ok = (rel >= RelW'(3)) && (r1_q == 8'hFF) && ((r2_q & 8'hE0) == 8'hE0) &&
             (r2_q[2:1] == LayerIII) && (r2_q[4:3] != VerReserved) &&
             (r3_q[3:2] != 2'd3) && (r3_q[7:4] != 4'd0) && (r3_q[7:4] != 4'd15);
    side7  = {1'b0, side_lookup(ver_q, chm_q)};
    kx     = {1'b0, k_q} - side7;
    id3    = (pos_q == 32'd9) && (tag_q[0] == 8'h49) && (tag_q[1] == 8'h44) &&
             (tag_q[2] == 8'h33);

    if (cmd_i.byte_en) begin
      if (pos_q != 32'hFFFF_FFFF) pos_d = pos_q + 1'b1;
      if (in_reg) begin
        r1_d = r2_q; r2_d = r3_q; r3_d = b;
        case (phase_q)
          PH_SEARCH: begin
            if (hdr_ok) begin
              fo_d    = rel - RelW'(3);
              ver_d   = r2_q[4:3];
              bri_d   = r3_q[7:4];
              sri_d   = r3_q[3:2];
              chm_d   = b[7:6];
              k_d     = '0;
              phase_d = PH_COLLECT;
            end
          end
          PH_COLLECT: begin
            // capture Xing/Info fields relative to the side info offset
            if (k_q >= side7[5:0]) begin
              case (kx)
                7'd0: begin
                  xm_d = (b == 8'h58);
                  im_d = (b == 8'h49);
                end
                7'd1: begin
                  xm_d = xm_q & (b == 8'h69);
                  im_d = im_q & (b == 8'h6E);
                end
                7'd2: begin
                  xm_d = xm_q & (b == 8'h6E);
                  im_d = im_q & (b == 8'h66);
                end
                7'd3: begin
                  xm_d = xm_q & (b == 8'h67);
                  im_d = im_q & (b == 8'h6F);
                end
                7'd7: xflag_d = b[0];
                7'd8, 7'd9, 7'd10: xcnt_d = {xcnt_q[23:0], b};
                7'd11: begin
                  xcnt_d  = {xcnt_q[23:0], b};
                  xdone_d = 1'b1;
                end
                default: ;
              endcase
            end
            case (k_q)
              6'd32: vm_d = (b == 8'h56);
              6'd33: vm_d = vm_q & (b == 8'h42);
              6'd34: vm_d = vm_q & (b == 8'h52);
              6'd35: vm_d = vm_q & (b == 8'h49);
              6'd46, 6'd47, 6'd48: vcnt_d = {vcnt_q[23:0], b};
              6'd49: begin
                vcnt_d  = {vcnt_q[23:0], b};
                vdone_d = 1'b1;
              end
              default: ;
            endcase
            k_d = k_q + 1'b1;
            if (k_q == 6'(AfterDepth - 1)) phase_d = PH_IDLE;
          end
          default: ;
        endcase
      end
      // ID3 header complete: drop the speculative search and restart after the tag
      if (id3) begin
        start_d = 29'd10 + {1'b0, tag_q[6][6:0], tag_q[7][6:0], tag_q[8][6:0], b[6:0]};
        r1_d = '0; r2_d = '0; r3_d = '0;
        phase_d = PH_SEARCH; fo_d = '0;
        ver_d = '0; bri_d = '0; sri_d = '0; chm_d = '0;
        xdone_d = 1'b0; vdone_d = 1'b0;
      end
    end
    if (cmd_i.load) begin
      pos_d = '0; start_d = '0; r1_d = '0; r2_d = '0; r3_d = '0;
      phase_d = PH_SEARCH; fo_d = '0;
      ver_d = '0; bri_d = '0; sri_d = '0; chm_d = '0;
      xdone_d = 1'b0; vdone_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0; start_q <= '0; r1_q <= '0; r2_q <= '0; r3_q <= '0;
      phase_q <= PH_SEARCH; fo_q <= '0;
      ver_q <= '0; bri_q <= '0; sri_q <= '0; chm_q <= '0;
      k_q <= '0; xm_q <= 1'b0; im_q <= 1'b0; xflag_q <= 1'b0; xdone_q <= 1'b0;
      vm_q <= 1'b0; vdone_q <= 1'b0; xcnt_q <= '0; vcnt_q <= '0;
    end else begin
      pos_q <= pos_d; start_q <= start_d; r1_q <= r1_d; r2_q <= r2_d; r3_q <= r3_d;
      phase_q <= phase_d; fo_q <= fo_d;
      ver_q <= ver_d; bri_q <= bri_d; sri_q <= sri_d; chm_q <= chm_d;
      k_q <= k_d; xm_q <= xm_d; im_q <= im_d; xflag_q <= xflag_d; xdone_q <= xdone_d;
      vm_q <= vm_d; vdone_q <= vdone_d; xcnt_q <= xcnt_d; vcnt_q <= vcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.byte_en && (pos_q < 32'd10)) tag_q[pos_q[3:0]] <= b;
    if (cmd_i.eof_byte) fsize_q <= {1'b0, pos_q} + 33'd1;
  end

  // operand setup for the final divide
  logic            x_ok, v_ok, mp1;
  logic [31:0]     total;
  logic [42:0]     nprod;
  logic [32:0]     bytes;
  logic [8:0]      kbps;
  logic [15:0]     rate;
  logic [NumW-1:0] num_ld;
  logic [DenW-1:0] den_ld;
  logic [1:0]      src_ld;

  always_comb begin
    mp1   = (ver_q == VerMpeg1);
    rate  = rate_lookup(ver_q, sri_q);
    kbps  = kbps_lookup(ver_q, bri_q);
    x_ok  = xdone_q && (xm_q || im_q);
    v_ok  = vdone_q && vm_q;
    total = x_ok ? (xflag_q ? xcnt_q : 32'd0) : (v_ok ? vcnt_q : 32'd0);
    nprod = 43'(total) * (mp1 ? 43'd1152 : 43'd576);
    bytes = fsize_q - {4'b0, start_q} - 33'(fo_q);
    if (phase_q == PH_SEARCH) begin
      num_ld = '0;
      den_ld = DenW'(1);
      src_ld = SRC_NONE;
    end else if (total != 32'd0) begin
      num_ld = NumW'({nprod, 1'b0}) + NumW'(rate);
      den_ld = DenW'({rate, 1'b0});
      src_ld = x_ok ? SRC_XING : SRC_VBRI;
    end else begin
      num_ld = NumW'({bytes, 3'b0}) + NumW'(19'(kbps) * 19'd500);
      den_ld = DenW'(19'(kbps) * 19'd1000);
      src_ld = SRC_BITRATE;
    end
  end

  logic [DenW:0] rem_sh;
  always_comb rem_sh = {rem_q, quo_q[NumW-1]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      quo_q <= num_ld;
      rem_q <= '0;
      den_q <= den_ld;
      src_q <= src_ld;
    end else if (cmd_i.div_step) begin
      if (rem_sh >= {1'b0, den_q}) begin
        rem_q <= DenW'(rem_sh - {1'b0, den_q});
        quo_q <= {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[DenW-1:0];
        quo_q <= {quo_q[NumW-2:0], 1'b0};
      end
    end
  end

  assign out_data_o.duration_seconds = quo_q[29:0];
  assign out_data_o.duration_source  = src_q;

  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.byte_en && id3) |=> (phase_q == PH_SEARCH && start_q >= 29'd10))
    else $error("restart after tag header");
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |=> (pos_q == 32'd0 && phase_q == PH_SEARCH)) else $error("not cleared");
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xdone_q |-> (phase_q != PH_SEARCH)) else $error("tag capture without header");

endmodule

>>> sv/mp3_duration_estimator.sv
// MP3 play-time estimator. Takes one file byte per cycle while streaming; the
// byte with end_of_file set is followed by an operand-setup state and a
// bit-serial divide, and no bytes are taken until the result is taken (the
// next file's first byte may enter in the cycle the result is taken). The
// divider sets most of the per-file latency.
// An ID3 tag is skipped, the first Layer III header in REGION_BYTES bytes is
// found, and Xing/Info or VBRI frame counts are used before a bitrate guess.
// Depends on mp3de_pkg, mp3de_ctrl, mp3de_dp.
module mp3_duration_estimator #(
  parameter int unsigned REGION_BYTES = 65536
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  mp3de_pkg::in_item_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output mp3de_pkg::out_item_t out_data_o
);
  import mp3de_pkg::*;

  dp_cmd_t cmd;

  mp3de_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_eof_i    (in_data_i.end_of_file),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  mp3de_dp #(
    .REGION_BYTES (REGION_BYTES)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o)
  );

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for mp3_duration_estimator: streams random and hand-made
// MP3-like files and checks each duration result against an in-bench predictor.
// Depends on mp3de_pkg and the estimator RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mp3de_pkg::*;

  localparam int unsigned RegionBytes = 65536;
  localparam int unsigned TailDepth = 52;
  localparam int unsigned CycleLimit = 400000;

  class duration_board;
    logic [31:0] file_pos;
    logic [7:0]  id3_bytes[10];
    logic [31:0] audio_base;
    logic [7:0]  window[4];
    phase_e      phase;
    logic [31:0] hdr_offset;
    logic [9:0]  hdr_bits;
    logic [7:0]  tail[TailDepth];
    int unsigned kb1[16];
    int unsigned kb2[16];
    int unsigned rates[16];
    out_item_t   due[$];
    int          errors;
    int          results;

    function new();
      kb1 = '{0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 0};
      kb2 = '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0};
      rates = '{11025, 12000, 8000, 0, 0, 0, 0, 0,
                22050, 24000, 16000, 0, 44100, 48000, 32000, 0};
      errors = 0;
      results = 0;
      clear_file();
    endfunction

    function void clear_search();
      foreach (window[k]) window[k] = 8'h00;
      foreach (tail[k]) tail[k] = 8'h00;
      phase = PH_SEARCH;
      hdr_offset = 0;
      hdr_bits = '0;
    endfunction

    function void clear_file();
      file_pos = 0;
      foreach (id3_bytes[k]) id3_bytes[k] = 8'h00;
      audio_base = 0;
      clear_search();
    endfunction

    function void scan_byte(logic [31:0] rel, logic [7:0] b);
      logic [1:0]  ver, lay, sri;
      logic [3:0]  bri;
      logic [31:0] k;
      window[0] = window[1];
      window[1] = window[2];
      window[2] = window[3];
      window[3] = b;
      if (phase == PH_SEARCH) begin
        if (rel < 3 || window[0] != 8'hFF || (window[1] & 8'hE0) != 8'hE0) return;
        ver = window[1][4:3];
        lay = window[1][2:1];
        bri = window[2][7:4];
        sri = window[2][3:2];
        if (lay != 2'd1 || ver == 2'd1 || sri == 2'd3 || bri == 4'd0 || bri == 4'd15)
          return;
        hdr_offset = rel - 3;
        hdr_bits = {ver, bri, sri, window[3][7:6]};
        phase = PH_COLLECT;
      end else if (phase == PH_COLLECT) begin
        k = rel - hdr_offset - 4;
        if (k < TailDepth) tail[k] = b;
        if (k + 1 >= TailDepth) phase = PH_IDLE;
      end
    endfunction

    function logic [31:0] word_at(int unsigned p);
      return {tail[p], tail[p+1], tail[p+2], tail[p+3]};
    endfunction

    function out_item_t file_duration(longint unsigned fsize);
      longint unsigned span, dur, n, nbytes, off;
      logic [1:0]  ver, sri, chm;
      logic [3:0]  bri;
      int unsigned rate, kbps, spf, side;
      logic [31:0] frames;
      src_e        src;
      out_item_t   r;
      r = '0;
      if (longint'(audio_base) >= fsize || phase == PH_SEARCH) return r;
      span = fsize - audio_base;
      if (span > RegionBytes) span = RegionBytes;
      off = hdr_offset;
      {ver, bri, sri, chm} = hdr_bits;
      rate = rates[{ver, sri}];
      kbps = (ver == 2'd3) ? kb1[bri] : kb2[bri];
      spf = (ver == 2'd3) ? 1152 : 576;
      if (ver == 2'd3) side = (chm == 2'd3) ? 17 : 32;
      else side = (chm == 2'd3) ? 9 : 17;
      frames = 0;
      src = SRC_NONE;
      dur = 0;
      if (off + 4 + side + 12 <= span &&
          (word_at(side) == "Xing" || word_at(side) == "Info")) begin
        if (word_at(side + 4) & 32'd1) frames = word_at(side + 8);
        src = SRC_XING;
      end else if (off + 4 + 32 + 18 <= span && word_at(32) == "VBRI") begin
        frames = word_at(46);
        src = SRC_VBRI;
      end
      if (frames > 0 && rate > 0) begin
        n = longint'(frames) * spf;
        dur = (2 * n + rate) / (2 * longint'(rate));
      end else if (kbps > 0) begin
        nbytes = fsize - audio_base - off;
        dur = (8 * nbytes + 500 * longint'(kbps)) / (1000 * longint'(kbps));
        src = SRC_BITRATE;
      end else begin
        src = SRC_NONE;
      end
      r.duration_seconds = dur[29:0];
      r.duration_source = src;
      return r;
    endfunction

    function void note_byte(in_item_t it);
      logic [31:0] p;
      p = file_pos;
      if (p < 10) id3_bytes[p] = it.data_byte;
      if (p >= audio_base && p - audio_base < RegionBytes) scan_byte(p - audio_base, it.data_byte);
      if (p == 9 && id3_bytes[0] == "I" && id3_bytes[1] == "D" && id3_bytes[2] == "3") begin
        audio_base = 10 + {id3_bytes[6][6:0], id3_bytes[7][6:0],
                           id3_bytes[8][6:0], id3_bytes[9][6:0]};
        clear_search();
      end
      if (file_pos != 32'hFFFF_FFFF) file_pos++;
      if (it.end_of_file) begin
        due.push_back(file_duration(longint'(p) + 1));
        clear_file();
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      results++;
      if (due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: %0d src %0d",
                                   got.duration_seconds, got.duration_source);
        return;
      end
      want = due.pop_front();
      if (got.duration_seconds !== want.duration_seconds ||
          got.duration_source !== want.duration_source) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected %0d src %0d, got %0d src %0d",
                   want.duration_seconds, want.duration_source,
                   got.duration_seconds, got.duration_source);
      end
    endfunction
  endclass

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_item_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_data_o;

  duration_board board = new();
  int        send_gap_pct = 0;
  int        recv_gap_pct = 0;
  int        hold_left = 0;
  int        bytes_sent = 0;
  int        cycles = 0;
  logic [7:0] file_bytes[$];

  mp3_duration_estimator DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // Receiver: a long hold-off wins over random back-pressure.
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_gap_pct);
    end
  end

  always @(negedge clk_i) begin
    out_item_t seen;
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen = out_data_o;
      @(posedge clk_i);
      board.check_result(seen);
    end
  end

  task automatic send_byte(logic [7:0] b, logic eof);
    in_item_t it;
    logic     taken;
    it.data_byte = b;
    it.end_of_file = eof;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do begin
      @(negedge clk_i);
      taken = in_ready_o;
      @(posedge clk_i);
    end while (!taken);
    board.note_byte(it);
    bytes_sent++;
  endtask

  task automatic send_file();
    foreach (file_bytes[k]) send_byte(file_bytes[k], k == file_bytes.size() - 1);
    file_bytes.delete();
  endtask

  task automatic push_rand(int n);
    repeat (n) file_bytes.push_back(8'($urandom));
  endtask

  // Build one file: random bytes only, or an optional ID3 tag, garbage, a frame header, a tag block, trailer.
  task automatic build_file();
    int unsigned tag_len, pick, side, body;
    logic [1:0]  ver, chm;
    logic [7:0]  body_bytes[TailDepth];
    logic [31:0] cnt;
    pick = $urandom_range(9);
    if (pick == 0) begin
      push_rand($urandom_range(1, 15));
      return;
    end
    if ($urandom_range(9) < 4) begin
      file_bytes.push_back("I");
      file_bytes.push_back("D");
      file_bytes.push_back("3");
      push_rand(3);
      if ($urandom_range(9) == 0) begin
        push_rand(4);
        tag_len = 0;
      end else begin
        tag_len = $urandom_range(0, 12);
        for (int k = 0; k < 3; k++) file_bytes.push_back({1'($urandom_range(1)), 7'd0});
        file_bytes.push_back({1'($urandom_range(1)), 7'(tag_len)});
      end
      push_rand(tag_len);
    end
    push_rand($urandom_range(0, 4));
    if ($urandom_range(9) == 0) begin
      push_rand(4);
    end else begin
      ver = $urandom_range(9) == 0 ? 2'($urandom) : ($urandom_range(1) ? 2'd3 : 2'd2);
      chm = 2'($urandom);
      file_bytes.push_back(8'hFF);
      file_bytes.push_back({3'b111, ver, 2'd1, 1'($urandom)});
      file_bytes.push_back({4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)),
                            2'($urandom)});
      file_bytes.push_back({chm, 6'($urandom)});
    end
    ver = file_bytes[file_bytes.size() - 3][4:3];
    chm = file_bytes[file_bytes.size() - 1][7:6];
    if (ver == 2'd3) side = (chm == 2'd3) ? 17 : 32;
    else side = (chm == 2'd3) ? 9 : 17;
    foreach (body_bytes[k]) body_bytes[k] = $urandom_range(3) == 0 ? 8'($urandom) : 8'h00;
    cnt = $urandom_range(4) == 0 ? 32'($urandom) : 32'($urandom_range(0, 20000));
    pick = $urandom_range(5);
    body = $urandom_range(0, 8);
    if (pick <= 1) begin
      {body_bytes[side], body_bytes[side+1], body_bytes[side+2], body_bytes[side+3]} =
        pick == 0 ? "Xing" : "Info";
      body_bytes[side+7] = {7'($urandom), 1'($urandom_range(3) != 0)};
      {body_bytes[side+8], body_bytes[side+9], body_bytes[side+10],
       body_bytes[side+11]} = cnt;
      body = side + 12 - $urandom_range(0, 3) * ($urandom_range(4) == 0);
    end else if (pick <= 3) begin
      {body_bytes[32], body_bytes[33], body_bytes[34], body_bytes[35]} = "VBRI";
      {body_bytes[46], body_bytes[47], body_bytes[48], body_bytes[49]} = cnt;
      body = 50 - $urandom_range(0, 3) * ($urandom_range(4) == 0);
    end
    for (int k = 0; k < body; k++) file_bytes.push_back(body_bytes[k]);
    push_rand($urandom_range(0, 12));
  endtask

  task automatic run_phase(int sgap, int rgap, int quota, int min_files);
    int start_bytes, files;
    send_gap_pct = sgap;
    recv_gap_pct = rgap;
    start_bytes = bytes_sent;
    files = 0;
    while (bytes_sent - start_bytes < quota || files < min_files) begin
      build_file();
      send_file();
      files++;
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // One-byte file, an ID3 tag reaching exactly to the end, a bare header.
    file_bytes = '{8'hFF};
    send_file();
    file_bytes = '{"I", "D", "3", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    send_file();
    file_bytes = '{8'hFF, 8'hFB, 8'hE0, 8'hC0, 8'h00, 8'h80, 8'h7F, 8'h00};
    send_file();
    run_phase(20, 66, 350, 4);
    run_phase(66, 20, 350, 4);
    hold_left = 400;
    run_phase(0, 0, 350, 4);
    in_valid_i <= 1'b0;
    while (board.due.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

>>> filelist.f
sv/mp3de_pkg.sv
sv/mp3de_ctrl.sv
sv/mp3de_dp.sv
sv/mp3_duration_estimator.sv
dv/tb_top.sv
